>>> rtl/core/ssp_pkg.sv
// Shared types and constants for the single-source shortest paths block.
// No dependencies; every other file in rtl/core except ssp_ram refers to it by scoped names.
package ssp_pkg;

    localparam int NODE_W   = 6;
    localparam int CNT_W    = 7;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 30;
    localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;

    localparam logic [DIST_W-1:0] UNREACHED = 30'd1000000000;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd1;

    // Sequencer states
    typedef enum logic [9:0] {
        S_LOAD     = 10'b00_0000_0001,
        S_INIT     = 10'b00_0000_0010,
        S_SCAN_RD  = 10'b00_0000_0100,
        S_SCAN_CMP = 10'b00_0000_1000,
        S_EDGE_RD  = 10'b00_0001_0000,
        S_EDGE_CHK = 10'b00_0010_0000,
        S_DIST_CMP = 10'b00_0100_0000,
        S_OUT_RD   = 10'b00_1000_0000,
        S_OUT_LOAD = 10'b01_0000_0000,
        S_OUT_HOLD = 10'b10_0000_0000
    } state_t;

    // Stored edge record
    typedef struct packed {
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [WEIGHT_W-1:0] weight;
    } edge_rec_t;

    // Operands and results of the shared add/compare unit
    typedef struct packed {
        logic [DIST_W-1:0]   base;
        logic [WEIGHT_W-1:0] addend;
        logic [DIST_W-1:0]   limit;
    } alu_req_t;

    typedef struct packed {
        logic [DIST_W-1:0] sum;
        logic              less;
    } alu_rsp_t;

endpackage

>>> rtl/core/ssp_if.sv
// Handshake channel interfaces: edge input, result output, configuration writes.
// Depends on ssp_pkg.
interface ssp_edge_if;
    logic                             valid;
    logic                             ready;
    logic [ssp_pkg::NODE_W-1:0]       from_node;
    logic [ssp_pkg::NODE_W-1:0]       to_node;
    logic [ssp_pkg::WEIGHT_W-1:0]     weight;
    logic                             last_edge;
    modport source (output valid, from_node, to_node, weight, last_edge, input ready);
    modport sink   (input valid, from_node, to_node, weight, last_edge, output ready);
endinterface

interface ssp_result_if;
    logic                             valid;
    logic                             ready;
    logic [ssp_pkg::NODE_W-1:0]       node_index;
    logic [ssp_pkg::DIST_W-1:0]       distance;
    logic                             reachable;
    logic                             edge_overflow;
    logic                             last;
    modport source (output valid, node_index, distance, reachable, edge_overflow, last,
                    input ready);
    modport sink   (input valid, node_index, distance, reachable, edge_overflow, last,
                    output ready);
endinterface

interface ssp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ssp_pkg::CFG_IDX_W-1:0]    index;
    logic [ssp_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ssp_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module ssp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 30
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/ssp_alu.sv
// Shared add/compare unit: sum = base + addend, less = sum < limit.
// Depends on ssp_pkg; used for both the minimum scan and edge relaxation.
module ssp_alu (
    input  ssp_pkg::alu_req_t req,
    output ssp_pkg::alu_rsp_t rsp
);
    logic [ssp_pkg::DIST_W-1:0] sum;

    assign sum      = req.base + ssp_pkg::DIST_W'(req.addend);
    assign rsp.sum  = sum;
    assign rsp.less = sum < req.limit;
endmodule

>>> rtl/core/single_source_shortest_paths.sv
// Single-source shortest paths: edges load one per cycle while in the load state; the last edge starts the search.
// Sequence: an init pass over all MAX_NODES distance entries, then a scan of the n nodes per pick
// plus one final scan, and a pass over every stored edge after each pick.
// Results: one node at a time, read, loaded and held until the sink takes it; no edge is taken until all are out.
// Throughput while loading: one edge per cycle; the search serializes on one RAM read port.
// Reset: asynchronous active low; clears the sequencer, edge count, flags, indexes, configuration and output valid.
module single_source_shortest_paths #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    ssp_edge_if.sink      edge_in,
    ssp_result_if.source  result_out,
    ssp_cfg_if.sink       cfg
);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int CW  = ssp_pkg::CNT_W;
    localparam int DW  = ssp_pkg::DIST_W;

    ssp_pkg::state_t state_reg, state_next;

    logic [ssp_pkg::NODE_W-1:0] source_reg;
    logic [CW-1:0]              node_count_reg;
    logic [ECW-1:0]             total_reg, total_next;
    logic                       ovf_reg, ovf_next;
    logic [NCW-1:0]             i_reg, i_next;
    logic [ECW-1:0]             e_reg, e_next;
    logic [DW-1:0]              best_reg, best_next;
    logic [NW-1:0]              pick_reg, pick_next;
    logic                       pick_vld_reg, pick_vld_next;
    logic [MAX_NODES-1:0]       done_reg, done_next;

    logic                       out_vld_reg, out_vld_next;
    logic [ssp_pkg::NODE_W-1:0] out_idx_reg, out_idx_next;
    logic [DW-1:0]              out_dist_reg, out_dist_next;
    logic                       out_reach_reg, out_reach_next;
    logic                       out_ovf_reg, out_ovf_next;
    logic                       out_last_reg, out_last_next;

    logic [CW-1:0]              n_eff;
    logic                       in_acc;
    logic                       edge_keep;
    ssp_pkg::edge_rec_t         edge_wr, edge_rd;
    logic                       dist_we;
    logic [NW-1:0]              dist_waddr, dist_raddr;
    logic [DW-1:0]              dist_wdata, dist_rd;
    ssp_pkg::alu_req_t          alu_req;
    ssp_pkg::alu_rsp_t          alu_rsp;
    logic                       src_ok;
    logic                       i_last, e_more, scan_take;

    // effective node count
    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = CW'(1);
        else if (node_count_reg > CW'(MAX_NODES))
            n_eff = CW'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    // configuration writes
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg     <= '0;
            node_count_reg <= CW'(64);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ssp_pkg::REG_SOURCE_NODE: source_reg     <= cfg.data[ssp_pkg::NODE_W-1:0];
                ssp_pkg::REG_NODE_COUNT:  node_count_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // edge store
    assign edge_in.ready = (state_reg == ssp_pkg::S_LOAD);
    assign in_acc        = edge_in.valid && edge_in.ready;
    assign edge_keep     = ({1'b0, edge_in.from_node} < n_eff) &&
                           ({1'b0, edge_in.to_node} < n_eff) &&
                           (total_reg < ECW'(MAX_EDGES));
    assign edge_wr       = '{from_node: edge_in.from_node, to_node: edge_in.to_node,
                             weight: edge_in.weight};

    ssp_ram #(.DEPTH(MAX_EDGES), .WIDTH(ssp_pkg::EDGE_W)) u_edge_ram (
        .clk   (clk),
        .we    (in_acc && edge_keep),
        .waddr (total_reg[EIW-1:0]),
        .wdata (edge_wr),
        .raddr (e_reg[EIW-1:0]),
        .rdata (edge_rd)
    );

    // distance store
    ssp_ram #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rd)
    );

    // shared add/compare unit: scan compares dist < best, relax compares best + w < dist
    always_comb
    begin
        if (state_reg == ssp_pkg::S_DIST_CMP)
            alu_req = '{base: best_reg, addend: edge_rd.weight, limit: dist_rd};
        else
            alu_req = '{base: dist_rd, addend: '0, limit: best_reg};
    end

    ssp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign src_ok    = {1'b0, source_reg} < n_eff;
    assign i_last    = (CW'(i_reg) + CW'(1)) >= n_eff;
    assign e_more    = ((ECW + 1)'(e_reg) + (ECW + 1)'(1)) < {1'b0, total_reg};
    assign scan_take = !done_reg[i_reg[NW-1:0]] && alu_rsp.less;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        e_next         = e_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        pick_vld_next  = pick_vld_reg;
        done_next      = done_reg;
        out_vld_next   = out_vld_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        out_reach_next = out_reach_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        dist_we        = 1'b0;
        dist_waddr     = i_reg[NW-1:0];
        dist_wdata     = ssp_pkg::UNREACHED;
        dist_raddr     = i_reg[NW-1:0];

        case (state_reg)
            ssp_pkg::S_LOAD:
            begin
                if (in_acc)
                begin
                    if (edge_keep)
                        total_next = total_reg + ECW'(1);
                    else
                        ovf_next = 1'b1;
                    if (edge_in.last_edge)
                    begin
                        state_next = ssp_pkg::S_INIT;
                        i_next     = '0;
                        done_next  = '0;
                    end
                end
            end

            // fill every distance entry, source gets zero if it is below the node count
            ssp_pkg::S_INIT:
            begin
                dist_we = 1'b1;
                if (src_ok && (CW'(i_reg) == {1'b0, source_reg}))
                    dist_wdata = '0;
                if (CW'(i_reg) == CW'(MAX_NODES - 1))
                begin
                    state_next    = ssp_pkg::S_SCAN_RD;
                    i_next        = '0;
                    best_next     = ssp_pkg::UNREACHED;
                    pick_vld_next = 1'b0;
                end
                else
                    i_next = i_reg + NCW'(1);
            end

            ssp_pkg::S_SCAN_RD:
                state_next = ssp_pkg::S_SCAN_CMP;

            // running minimum over unprocessed nodes
            ssp_pkg::S_SCAN_CMP:
            begin
                if (scan_take)
                begin
                    best_next     = dist_rd;
                    pick_next     = i_reg[NW-1:0];
                    pick_vld_next = 1'b1;
                end
                if (!i_last)
                begin
                    i_next     = i_reg + NCW'(1);
                    state_next = ssp_pkg::S_SCAN_RD;
                end
                else if (pick_vld_next)
                begin
                    done_next[pick_next] = 1'b1;
                    e_next               = '0;
                    if (total_reg == '0)
                    begin
                        i_next        = '0;
                        best_next     = ssp_pkg::UNREACHED;
                        pick_vld_next = 1'b0;
                        state_next    = ssp_pkg::S_SCAN_RD;
                    end
                    else
                        state_next = ssp_pkg::S_EDGE_RD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ssp_pkg::S_OUT_RD;
                end
            end

            ssp_pkg::S_EDGE_RD:
                state_next = ssp_pkg::S_EDGE_CHK;

            // edge record is out; fetch the head distance, relax if the edge leaves the pick with both ends in range
            ssp_pkg::S_EDGE_CHK:
            begin
                dist_raddr = edge_rd.to_node[NW-1:0];
                if ((edge_rd.from_node[NW-1:0] == pick_reg) &&
                    ({1'b0, edge_rd.from_node} < n_eff) &&
                    ({1'b0, edge_rd.to_node} < n_eff))
                    state_next = ssp_pkg::S_DIST_CMP;
                else if (e_more)
                begin
                    e_next     = e_reg + ECW'(1);
                    state_next = ssp_pkg::S_EDGE_RD;
                end
                else
                begin
                    i_next        = '0;
                    best_next     = ssp_pkg::UNREACHED;
                    pick_vld_next = 1'b0;
                    state_next    = ssp_pkg::S_SCAN_RD;
                end
            end

            // relax
            ssp_pkg::S_DIST_CMP:
            begin
                dist_waddr = edge_rd.to_node[NW-1:0];
                dist_wdata = alu_rsp.sum;
                dist_we    = alu_rsp.less;
                if (e_more)
                begin
                    e_next     = e_reg + ECW'(1);
                    state_next = ssp_pkg::S_EDGE_RD;
                end
                else
                begin
                    i_next        = '0;
                    best_next     = ssp_pkg::UNREACHED;
                    pick_vld_next = 1'b0;
                    state_next    = ssp_pkg::S_SCAN_RD;
                end
            end

            ssp_pkg::S_OUT_RD:
                state_next = ssp_pkg::S_OUT_LOAD;

            ssp_pkg::S_OUT_LOAD:
            begin
                out_vld_next   = 1'b1;
                out_idx_next   = ssp_pkg::NODE_W'(i_reg);
                out_dist_next  = dist_rd;
                out_reach_next = dist_rd < ssp_pkg::UNREACHED;
                out_ovf_next   = ovf_reg;
                out_last_next  = i_last;
                state_next     = ssp_pkg::S_OUT_HOLD;
            end

            ssp_pkg::S_OUT_HOLD:
            begin
                if (result_out.ready)
                begin
                    out_vld_next = 1'b0;
                    if (out_last_reg)
                    begin
                        total_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ssp_pkg::S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + NCW'(1);
                        state_next = ssp_pkg::S_OUT_RD;
                    end
                end
            end

            default:
                state_next = ssp_pkg::S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ssp_pkg::S_LOAD;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            e_reg        <= '0;
            pick_vld_reg <= 1'b0;
            done_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            ovf_reg      <= ovf_next;
            i_reg        <= i_next;
            e_reg        <= e_next;
            pick_vld_reg <= pick_vld_next;
            done_reg     <= done_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        out_idx_reg   <= out_idx_next;
        out_dist_reg  <= out_dist_next;
        out_reach_reg <= out_reach_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign result_out.valid         = out_vld_reg;
    assign result_out.node_index    = out_idx_reg;
    assign result_out.distance      = out_dist_reg;
    assign result_out.reachable     = out_reach_reg;
    assign result_out.edge_overflow = out_ovf_reg;
    assign result_out.last          = out_last_reg;

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.ready && result_out.last) |=>
        (state_reg == ssp_pkg::S_LOAD) && (total_reg == '0) && !ovf_reg)
        else $error("load not restarted after final result");

    a_relax_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssp_pkg::S_DIST_CMP) |-> pick_vld_reg)
        else $error("relaxation without a picked node");

    a_no_load_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid) |-> !edge_in.ready)
        else $error("edge taken while results pending");
endmodule
